[rtl/ic_pkg.sv]
// ----------------------------------------------------------------------------
// ic_pkg: shared types and constants for the incircle predicate
// Width of the tolerance register and its type, used by the channels and the
// decision stage.
// ----------------------------------------------------------------------------
package ic_pkg;

  // tolerance register width, fixed by the register map
  localparam int TOL_WIDTH = 32;

  typedef logic [TOL_WIDTH-1:0] tol_t;

endpackage

[rtl/ic_if.sv]
// ----------------------------------------------------------------------------
// ic_if: valid/ready channels of the incircle predicate
// Point-set request channel, result channel and tolerance write channel.
// ----------------------------------------------------------------------------

// point set: three circle points and the query point
interface ic_point_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;

  modport source (
    output valid, a_x, a_y, b_x, b_y, c_x, c_y, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, b_x, b_y, c_x, c_y, query_x, query_y,
    output ready
  );
endinterface

// one-bit inside/outside result
interface ic_result_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// tolerance register write
interface ic_cfg_if import ic_pkg::*; ();
  logic valid;
  logic ready;
  tol_t tolerance;

  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface

[rtl/ic_prep.sv]
// ----------------------------------------------------------------------------
// ic_prep: differences, pair products and squared lengths
// Three pipeline stages: coordinate differences from the query point, the six
// cross products and six squares, then the three squared lengths.
// ----------------------------------------------------------------------------
module ic_prep #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     a_x,
  input  logic signed [COORD_WIDTH-1:0]     a_y,
  input  logic signed [COORD_WIDTH-1:0]     b_x,
  input  logic signed [COORD_WIDTH-1:0]     b_y,
  input  logic signed [COORD_WIDTH-1:0]     c_x,
  input  logic signed [COORD_WIDTH-1:0]     c_y,
  input  logic signed [COORD_WIDTH-1:0]     query_x,
  input  logic signed [COORD_WIDTH-1:0]     query_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [2*COORD_WIDTH+1:0]   st [6],
  output logic        [2*COORD_WIDTH+1:0]   sq [3]
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NS = 3;

  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  logic signed [DW-1:0] dx [3];
  logic signed [DW-1:0] dy [3];
  logic signed [PW-1:0] st1 [6];
  logic signed [PW-1:0] sqx [3];
  logic signed [PW-1:0] sqy [3];
  logic signed [PW-1:0] st2 [6];
  logic        [PW-1:0] sq2 [3];

  // a stage loads when it is empty or its contents move on
  assign adv[NS] = out_ready;
  for (genvar g = 0; g < NS; g++) begin : g_adv
    assign adv[g] = !vld[g] || adv[g+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 0: differences from the query point
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx[0] <= $signed({a_x[COORD_WIDTH-1], a_x}) - $signed({query_x[COORD_WIDTH-1], query_x});
      dy[0] <= $signed({a_y[COORD_WIDTH-1], a_y}) - $signed({query_y[COORD_WIDTH-1], query_y});
      dx[1] <= $signed({b_x[COORD_WIDTH-1], b_x}) - $signed({query_x[COORD_WIDTH-1], query_x});
      dy[1] <= $signed({b_y[COORD_WIDTH-1], b_y}) - $signed({query_y[COORD_WIDTH-1], query_y});
      dx[2] <= $signed({c_x[COORD_WIDTH-1], c_x}) - $signed({query_x[COORD_WIDTH-1], query_x});
      dy[2] <= $signed({c_y[COORD_WIDTH-1], c_y}) - $signed({query_y[COORD_WIDTH-1], query_y});
    end
  end

  // stage 1: cross products in determinant term order, and squares
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      st1[0] <= dx[0] * dy[1];
      st1[1] <= dx[2] * dy[1];
      st1[2] <= dx[2] * dy[0];
      st1[3] <= dx[0] * dy[2];
      st1[4] <= dx[1] * dy[2];
      st1[5] <= dx[1] * dy[0];
      for (int i = 0; i < 3; i++) begin
        sqx[i] <= dx[i] * dx[i];
        sqy[i] <= dy[i] * dy[i];
      end
    end
  end

  // stage 2: squared lengths, never negative
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      st2 <= st1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= $unsigned(sqx[i]) + $unsigned(sqy[i]);
      end
    end
  end

  assign st = st2;
  assign sq = sq2;

endmodule

[rtl/ic_triple.sv]
// ----------------------------------------------------------------------------
// ic_triple: six triple products of the incircle determinant
// Each cross product times a squared length, split into four half-width
// partial products, then summed over two stages.
// ----------------------------------------------------------------------------
module ic_triple #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [2*COORD_WIDTH+1:0]   st [6],
  input  logic        [2*COORD_WIDTH+1:0]   sq [3],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [4*COORD_WIDTH+5:0]   trip [6]
);

  localparam int K    = COORD_WIDTH + 1;
  localparam int PW   = 2 * K;
  localparam int DETW = 4 * K + 2;
  localparam int NS   = 3;

  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  logic        [PW-1:0]   qsel [6];
  logic        [PW-1:0]   ll [6];
  logic        [PW-1:0]   lh [6];
  logic signed [PW:0]     hl [6];
  logic signed [PW:0]     hh [6];
  logic        [PW-1:0]   ll2 [6];
  logic signed [PW:0]     hh2 [6];
  logic signed [PW+1:0]   mid [6];
  logic signed [DETW-1:0] trip3 [6];

  assign adv[NS] = out_ready;
  for (genvar g = 0; g < NS; g++) begin : g_adv
    assign adv[g] = !vld[g] || adv[g+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // squared length that goes with each cross product
  assign qsel[0] = sq[2];
  assign qsel[1] = sq[0];
  assign qsel[2] = sq[1];
  assign qsel[3] = sq[1];
  assign qsel[4] = sq[0];
  assign qsel[5] = sq[2];

  // stage 0: partial products, signed high half of the cross product
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 6; i++) begin
        ll[i] <= st[i][K-1:0] * qsel[i][K-1:0];
        lh[i] <= st[i][K-1:0] * qsel[i][PW-1:K];
        hl[i] <= $signed(st[i][PW-1:K]) * $signed({1'b0, qsel[i][K-1:0]});
        hh[i] <= $signed(st[i][PW-1:K]) * $signed({1'b0, qsel[i][PW-1:K]});
      end
    end
  end

  // stage 1: middle terms
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 6; i++) begin
        mid[i] <= $signed({2'b00, lh[i]}) + $signed({hl[i][PW], hl[i]});
        ll2[i] <= ll[i];
        hh2[i] <= hh[i];
      end
    end
  end

  // stage 2: high and low terms abut, middle term shifted in
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 6; i++) begin
        trip3[i] <= $signed({hh2[i][PW], hh2[i], ll2[i]})
                  + $signed({{K{mid[i][PW+1]}}, mid[i], {K{1'b0}}});
      end
    end
  end

  assign trip = trip3;

endmodule

[rtl/ic_decide.sv]
// ----------------------------------------------------------------------------
// ic_decide: determinant sum and tolerance compare
// Adds the six signed triple products over three stages and compares the
// determinant against the tolerance in a fourth, which is the output register.
// ----------------------------------------------------------------------------
module ic_decide import ic_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tol_t                              tolerance,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [4*COORD_WIDTH+5:0]   trip [6],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              inside_res
);

  localparam int DETW = 4 * COORD_WIDTH + 6;
  localparam int NS   = 4;

  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  logic signed [DETW-1:0] pair [3];
  logic signed [DETW-1:0] sum01;
  logic signed [DETW-1:0] pair2;
  logic signed [DETW-1:0] det;
  logic                   in_circle;

  assign adv[NS] = out_ready;
  for (genvar g = 0; g < NS; g++) begin : g_adv
    assign adv[g] = !vld[g] || adv[g+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 0: positive minus negative term of each pair
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pair[0] <= trip[0] - trip[1];
      pair[1] <= trip[2] - trip[3];
      pair[2] <= trip[4] - trip[5];
    end
  end

  // stage 1: partial sum
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sum01 <= pair[0] + pair[1];
      pair2 <= pair[2];
    end
  end

  // stage 2: determinant
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      det <= sum01 + pair2;
    end
  end

  // stage 3: inside only for a positive determinant above tolerance
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      in_circle <= !det[DETW-1]
                && (det[DETW-2:0] > {{(DETW-1-TOL_WIDTH){1'b0}}, tolerance});
    end
  end

  assign inside_res = in_circle;

`ifndef SYNTHESIS
  // a negative determinant never reports inside
  assert property (@(posedge clk) disable iff (rst)
    vld[2] && adv[3] && det[DETW-1] |=> !in_circle)
    else $error("negative determinant reported inside");

  // a positive determinant beyond any tolerance always reports inside
  assert property (@(posedge clk) disable iff (rst)
    vld[2] && adv[3] && !det[DETW-1] && (|det[DETW-2:TOL_WIDTH]) |=> in_circle)
    else $error("large determinant not reported inside");

  // a blocked partial-sum stage keeps its request
  assert property (@(posedge clk) disable iff (rst)
    vld[1] && !adv[1] |=> vld[1] && $stable(sum01))
    else $error("stalled partial sum lost or changed");
`endif

endmodule

[rtl/incircle_predicate.sv]
// ----------------------------------------------------------------------------
// incircle_predicate: pipelined Delaunay incircle test
// Exact integer incircle determinant of three points and a query point,
// compared against a programmable tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   points: valid/ready request carrying a, b, c (counter-clockwise) and the
//     query point as signed COORD_WIDTH-bit coordinates.
//   result: valid/ready channel, inside_res = 1 when the determinant is
//     greater than the tolerance, one result per request, in order.
//   cfg: tolerance write, always ready; write only while no request is in
//     flight.
//   The pipeline has 10 register stages: 3 stages of differences and
//     products, 3 of triple products built from four half-width
//     multiplies each, 4 of summation and compare.
//   Throughput is one request per cycle while results are taken; every stage
//     has its own valid bit, so empty stages fill even while the result waits.
//   When the receiver stalls, stages back up one at a time; ready on points
//     drops only once all 10 stages hold a request. Nothing is lost or
//     repeated.
//   Reset clears all valid bits and sets the tolerance to 0.
// ----------------------------------------------------------------------------
module incircle_predicate import ic_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input logic        clk,
  input logic        rst,
  ic_point_if.sink   points,
  ic_result_if.source result,
  ic_cfg_if.sink     cfg
);

  localparam int PW   = 2 * COORD_WIDTH + 2;
  localparam int DETW = 4 * COORD_WIDTH + 6;

  tol_t tolerance;

  logic                   prep_valid;
  logic                   prep_ready;
  logic signed [PW-1:0]   st [6];
  logic        [PW-1:0]   sq [3];
  logic                   trip_valid;
  logic                   trip_ready;
  logic signed [DETW-1:0] trip [6];

  // tolerance register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg.valid) begin
      tolerance <= cfg.tolerance;
    end
  end

  // differences, cross products, squared lengths
  ic_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .a_x       (points.a_x),
    .a_y       (points.a_y),
    .b_x       (points.b_x),
    .b_y       (points.b_y),
    .c_x       (points.c_x),
    .c_y       (points.c_y),
    .query_x   (points.query_x),
    .query_y   (points.query_y),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .st        (st),
    .sq        (sq)
  );

  // triple products
  ic_triple #(.COORD_WIDTH(COORD_WIDTH)) u_triple (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .st        (st),
    .sq        (sq),
    .out_valid (trip_valid),
    .out_ready (trip_ready),
    .trip      (trip)
  );

  // determinant and decision
  ic_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
    .clk        (clk),
    .rst        (rst),
    .tolerance  (tolerance),
    .in_valid   (trip_valid),
    .in_ready   (trip_ready),
    .trip       (trip),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .inside_res (result.inside_res)
  );

endmodule
